### rtl/core/lsaw_pkg.sv
// Shared constants, types and helpers for the lattice walk step block.
// No dependencies; imported by lattice_self_avoiding_walk_step and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package lsaw_pkg;

  // Grid covers x,y in [-GRID_HALF, GRID_HALF-1]; one map row per x.
  localparam int GRID_HALF = 64;
  localparam int GRID_SIDE = 2 * GRID_HALF;
  localparam int IDX_W     = $clog2(GRID_SIDE);

  // Fixed field widths
  localparam int POS_W    = 7;
  localparam int STEP_W   = 6;
  localparam int WEIGHT_W = 32;
  localparam int RND_W    = 15;

  localparam logic [STEP_W-1:0]   WALK_LEN_RESET = STEP_W'(50);
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE     = 32'h4000_0000;
  // ceil(2^33 / 3): floor(w/3) = (w * RECIP3_W) >> 33 for any 32-bit w
  localparam logic [31:0]         RECIP3_W       = 32'hAAAA_AAAB;
  // (2^17 + 1) / 3: floor(r/3) = (r * RECIP3_R) >> 17 for any 15-bit r
  localparam logic [16:0]         RECIP3_R       = 17'h0_AAAB;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef enum logic [1:0] {
    ST_MOVED   = 2'd0,
    ST_TRAPPED = 2'd1,
    ST_IGNORED = 2'd2,
    ST_STARTED = 2'd3
  } status_t;

  // Neighbor order
  localparam logic [1:0] DIR_DN = 2'd0;
  localparam logic [1:0] DIR_UP = 2'd1;
  localparam logic [1:0] DIR_RT = 2'd2;
  localparam logic [1:0] DIR_LT = 2'd3;

  // Grid index to signed coordinate, low POS_W bits
  function automatic logic [POS_W-1:0] pos_of(input logic [IDX_W-1:0] idx);
    logic signed [31:0] v;
    v = $signed(32'(idx)) - GRID_HALF;
    return v[POS_W-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/core/lsaw_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lsaw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/lattice_self_avoiding_walk_step.sv
// Top level of the lattice walk step block: sequencer, map memory, weight math.
// Depends on lsaw_pkg and lsaw_ram.
//
// Usage
//   Input channel (in_valid / in_stall): one transfer per item. operation
//   START clears the visited map and puts the walker at the origin with
//   weight 1.0; operation STEP tries one move picked by random_value.
//   Result channel (out_valid / out_stall): exactly one transfer per item,
//   in item order. cfg_we / cfg_wdata write walk_length (reset 50).
//   Sequencing
//   - Step: the map port sets the sequence: three row reads (x, x+1,
//     x-1), then a read and a write of the target row. A trapped step
//     ends after the target read, with no write.
//   - Start: the map is swept one row a cycle.
//   - Ignored step: goes straight to the result hand-off.
//   The block takes one item at a time; in_stall is high from the transfer
//   until the result is loaded. The output register frees the core, but a
//   finished result waits in its last state while the previous one is
//   still stalled.
//   Reset
//   - Control state clears, no walk is active, walk_length returns to 50.
//     The map RAM is not cleared: steps are ignored until a start, and a
//     start sweeps the whole map, so stale contents are never read.
`timescale 1ns / 1ps
`default_nettype none

module lattice_self_avoiding_walk_step
  import lsaw_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  // input channel
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_operation,
  input  wire logic [RND_W-1:0]    in_random_value,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [1:0]               out_status,
  output logic [POS_W-1:0]         out_pos_x,
  output logic [POS_W-1:0]         out_pos_y,
  output logic [STEP_W-1:0]        out_step_index,
  output logic [WEIGHT_W-1:0]      out_weight,
  output logic                     out_walk_done,
  // configuration
  input  wire logic                cfg_we,
  input  wire logic [STEP_W-1:0]   cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLR,   // map sweep for a start
    S_RD0,   // read row x
    S_RD1,   // read row x+1, take up/down bits
    S_RD2,   // read row x-1, take right bit
    S_DEC,   // take left bit, pick move, read target row
    S_WR,    // mark target cell, update weight
    S_FIN    // hand result to the output register
  } state_t;

  state_t               state_r;

  // walk state
  logic [IDX_W-1:0]     xi_r, yi_r;
  logic [STEP_W-1:0]    steps_r;
  logic [WEIGHT_W-1:0]  weight_r;
  logic                 active_r;
  logic [STEP_W-1:0]    walk_len_r;

  // per-item work registers
  logic [RND_W-1:0]     rnd_r;
  logic [1:0]           rmod3_r;
  logic                 free_dn_r, free_up_r, free_rt_r;
  logic [2:0]           count_r;
  logic [63:0]          prod_r;
  logic [IDX_W-1:0]     clr_cnt_r;
  status_t              status_r;
  logic                 done_r;

  // output register
  logic                 out_valid_r;
  status_t              out_status_r;
  logic [POS_W-1:0]     out_pos_x_r, out_pos_y_r;
  logic [STEP_W-1:0]    out_step_r;
  logic [WEIGHT_W-1:0]  out_weight_r;
  logic                 out_done_r;

  // map memory: row = x index, bit = y index
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr, mem_raddr;
  logic [GRID_SIDE-1:0] mem_wdata, mem_rdata;

  lsaw_ram #(
    .WIDTH (GRID_SIDE),
    .DEPTH (GRID_SIDE)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // ---------------------------------------------------------------
  // Move decision (S_DEC)
  // ---------------------------------------------------------------
  logic                 free_lt;
  logic [3:0]           free_mask;
  logic [2:0]           count;
  logic [1:0]           ksel;
  logic [1:0]           pick;
  logic [1:0]           seen;
  logic [IDX_W-1:0]     nx, ny;

  assign free_lt   = (xi_r != '0) && !mem_rdata[yi_r];
  assign free_mask = {free_lt, free_rt_r, free_up_r, free_dn_r};
  assign count     = 3'(free_mask[0]) + 3'(free_mask[1])
                   + 3'(free_mask[2]) + 3'(free_mask[3]);

  always_comb begin
    case (count)
      3'd2:    ksel = {1'b0, rnd_r[0]};
      3'd3:    ksel = rmod3_r;
      3'd4:    ksel = rnd_r[1:0];
      default: ksel = 2'd0;
    endcase
  end

  // ksel-th free neighbor in list order
  always_comb begin
    pick = DIR_DN;
    seen = 2'd0;
    for (int j = 0; j < 4; j++) begin
      if (free_mask[j]) begin
        if (seen == ksel) pick = 2'(j);
        seen = seen + 2'd1;
      end
    end
  end

  always_comb begin
    nx = xi_r;
    ny = yi_r;
    unique case (pick)
      DIR_DN: ny = yi_r - IDX_W'(1);
      DIR_UP: ny = yi_r + IDX_W'(1);
      DIR_RT: nx = xi_r + IDX_W'(1);
      DIR_LT: nx = xi_r - IDX_W'(1);
      default: ;
    endcase
  end

  // random_value mod 3 by reciprocal
  logic [31:0] rq3_prod;
  logic [14:0] rq3;
  logic [16:0] rq3x3;
  assign rq3_prod = 32'(rnd_r) * 32'(RECIP3_R);
  assign rq3      = rq3_prod[31:17];
  assign rq3x3    = {1'b0, rq3, 1'b0} + {2'b0, rq3};

  // ---------------------------------------------------------------
  // Weight update (S_WR): floor(w * count / 3), saturated
  // q = floor(w/3), r = w - 3q; floor(k*w/3) = k*q + floor(k*r/3)
  // ---------------------------------------------------------------
  logic [30:0]          wq;
  logic [32:0]          wq3;
  logic [1:0]           wrem;
  logic [34:0]          wsum;
  logic [WEIGHT_W-1:0]  weight_new;

  assign wq   = prod_r[63:33];
  assign wq3  = {1'b0, wq, 1'b0} + {2'b0, wq};
  assign wrem = weight_r[1:0] - wq3[1:0];

  always_comb begin
    case (count_r)
      3'd1:    wsum = 35'(wq);
      3'd2:    wsum = 35'({wq, 1'b0}) + 35'(wrem == 2'd2);
      3'd3:    wsum = 35'(weight_r);
      3'd4:    wsum = 35'({wq, 2'b00})
                    + ((wrem == 2'd0) ? 35'd0 : (wrem == 2'd1) ? 35'd1 : 35'd2);
      default: wsum = '0;
    endcase
  end

  assign weight_new = (|wsum[34:32]) ? '1 : wsum[WEIGHT_W-1:0];

  // ---------------------------------------------------------------
  // Memory port control
  // ---------------------------------------------------------------
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = xi_r;
    mem_wdata = mem_rdata | (GRID_SIDE'(1) << yi_r);
    mem_raddr = xi_r;
    unique case (state_r)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        // the origin cell is marked during the sweep
        mem_wdata = (clr_cnt_r == IDX_W'(GRID_HALF)) ?
                    (GRID_SIDE'(1) << GRID_HALF) : '0;
      end
      S_RD1:   mem_raddr = xi_r + IDX_W'(1);
      S_RD2:   mem_raddr = xi_r - IDX_W'(1);
      S_DEC:   mem_raddr = nx;
      S_WR:    mem_we    = 1'b1;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------
  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      xi_r        <= IDX_W'(GRID_HALF);
      yi_r        <= IDX_W'(GRID_HALF);
      steps_r     <= '0;
      weight_r    <= WEIGHT_ONE;
      active_r    <= 1'b0;
      walk_len_r  <= WALK_LEN_RESET;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        walk_len_r <= cfg_wdata;
      end
      // load a new result, else drop the one just taken
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            rnd_r  <= in_random_value;
            done_r <= 1'b0;
            if (in_operation == OP_START) begin
              clr_cnt_r <= '0;
              state_r   <= S_CLR;
            end else if (!active_r || steps_r >= walk_len_r) begin
              status_r <= ST_IGNORED;
              state_r  <= S_FIN;
            end else begin
              state_r <= S_RD0;
            end
          end
        end
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + IDX_W'(1);
          if (clr_cnt_r == IDX_W'(GRID_SIDE - 1)) begin
            xi_r     <= IDX_W'(GRID_HALF);
            yi_r     <= IDX_W'(GRID_HALF);
            steps_r  <= '0;
            weight_r <= WEIGHT_ONE;
            active_r <= 1'b1;
            status_r <= ST_STARTED;
            state_r  <= S_FIN;
          end
        end
        S_RD0: begin
          rmod3_r <= 2'(17'(rnd_r) - rq3x3);
          state_r <= S_RD1;
        end
        S_RD1: begin
          free_dn_r <= (yi_r != '0) && !mem_rdata[yi_r - IDX_W'(1)];
          free_up_r <= (yi_r != IDX_W'(GRID_SIDE - 1)) && !mem_rdata[yi_r + IDX_W'(1)];
          state_r   <= S_RD2;
        end
        S_RD2: begin
          free_rt_r <= (xi_r != IDX_W'(GRID_SIDE - 1)) && !mem_rdata[yi_r];
          state_r   <= S_DEC;
        end
        S_DEC: begin
          count_r <= count;
          prod_r  <= 64'(weight_r) * 64'(RECIP3_W);
          if (count == 3'd0) begin
            active_r <= 1'b0;
            status_r <= ST_TRAPPED;
            state_r  <= S_FIN;
          end else begin
            xi_r    <= nx;
            yi_r    <= ny;
            state_r <= S_WR;
          end
        end
        S_WR: begin
          weight_r <= weight_new;
          steps_r  <= steps_r + STEP_W'(1);
          status_r <= ST_MOVED;
          if (steps_r + STEP_W'(1) == walk_len_r) begin
            done_r   <= 1'b1;
            active_r <= 1'b0;
          end
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_status_r <= status_r;
            out_pos_x_r  <= pos_of(xi_r);
            out_pos_y_r  <= pos_of(yi_r);
            out_step_r   <= steps_r;
            out_weight_r <= weight_r;
            out_done_r   <= done_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_pos_x      = out_pos_x_r;
  assign out_pos_y      = out_pos_y_r;
  assign out_step_index = out_step_r;
  assign out_weight     = out_weight_r;
  assign out_walk_done  = out_done_r;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  // a new result only comes from the hand-off state
  a_load_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result loaded outside hand-off state");

  // walk completion is only reported on a move
  a_done_on_move: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> out_status_r == ST_MOVED)
    else $error("walk_done on a non-move result");

  // a move always has at least one free neighbor behind it
  a_wr_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WR |-> count_r != 3'd0)
    else $error("cell write with no free neighbor");

  // a trapped or completed walk is no longer active
  a_trap_stops: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN && (status_r == ST_TRAPPED || done_r) |-> !active_r)
    else $error("walk still active after trap or completion");

endmodule

`default_nettype wire

### sim/tb_lattice_self_avoiding_walk_step.sv
// Self-checking testbench for lattice_self_avoiding_walk_step: random walks checked
// against an in-bench walk predictor. Depends on lsaw_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_lattice_self_avoiding_walk_step
  import lsaw_pkg::*;
();

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 900;
  localparam int HOLD_AFTER   = 40;   // accepted inputs before the long output hold
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 200;  // covers the map sweep of a start

  // Neighbor deltas in scan order: down, up, right, left
  localparam int STEP_DX [4] = '{0, 0, 1, -1};
  localparam int STEP_DY [4] = '{-1, 1, 0, 0};
  // rnd = base + 12*k keeps choosing the same direction on a straight line:
  // base mod 4 picks it at the origin, base mod 3 picks it afterwards.
  localparam int STRAIGHT_BASE [4] = '{0, 9, 2, 11};

  typedef struct packed {
    logic             op;
    logic [RND_W-1:0] rnd;
  } walk_item_t;

  typedef struct packed {
    status_t             status;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
    logic [STEP_W-1:0]   step_index;
    logic [WEIGHT_W-1:0] weight;
    logic                walk_done;
  } walk_report_t;

  // ---------------------------------------------------------------------------
  // DUT hookup; every input has a known value from time zero
  // ---------------------------------------------------------------------------
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_operation = OP_START;
  logic [RND_W-1:0]    in_random_value = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          out_status;
  logic [POS_W-1:0]    out_pos_x;
  logic [POS_W-1:0]    out_pos_y;
  logic [STEP_W-1:0]   out_step_index;
  logic [WEIGHT_W-1:0] out_weight;
  logic                out_walk_done;
  logic                cfg_we = 1'b0;
  logic [STEP_W-1:0]   cfg_wdata = '0;

  lattice_self_avoiding_walk_step dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_random_value (in_random_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_step_index  (out_step_index),
    .out_weight      (out_weight),
    .out_walk_done   (out_walk_done),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Walk predictor: its own map, walker and walk_length copy
  // ---------------------------------------------------------------------------
  bit                  visited [GRID_SIDE][GRID_SIDE];  // [x + GRID_HALF][y + GRID_HALF]
  int                  walker_x = 0;
  int                  walker_y = 0;
  logic [STEP_W-1:0]   walk_steps = '0;
  logic [WEIGHT_W-1:0] walk_weight = WEIGHT_ONE;
  logic                walk_running = 1'b0;
  logic [STEP_W-1:0]   walk_len = WALK_LEN_RESET;

  task automatic grow_walk(input walk_item_t it, output walk_report_t rep);
    int          nx;
    int          ny;
    int          count;
    int          pick;
    int          free_dir [4];
    logic [63:0] prod;
    rep.walk_done = 1'b0;
    if (it.op == OP_START) begin
      for (int x = 0; x < GRID_SIDE; x++)
        for (int y = 0; y < GRID_SIDE; y++)
          visited[x][y] = 1'b0;
      walker_x = 0;
      walker_y = 0;
      visited[GRID_HALF][GRID_HALF] = 1'b1;
      walk_steps = '0;
      walk_weight = WEIGHT_ONE;
      walk_running = 1'b1;
      rep.status = ST_STARTED;
    end else if (!walk_running || walk_steps >= walk_len) begin
      // no walk, or walk_length already reached (also after a lowered write)
      rep.status = ST_IGNORED;
    end else begin
      count = 0;
      for (int d = 0; d < 4; d++) begin
        nx = walker_x + STEP_DX[d];
        ny = walker_y + STEP_DY[d];
        // off-grid neighbors count as occupied
        if (nx >= -GRID_HALF && nx < GRID_HALF && ny >= -GRID_HALF && ny < GRID_HALF &&
            !visited[nx + GRID_HALF][ny + GRID_HALF]) begin
          free_dir[count] = d;
          count++;
        end
      end
      if (count == 0) begin
        walk_running = 1'b0;
        rep.status = ST_TRAPPED;
      end else begin
        pick = free_dir[int'(it.rnd) % count];
        walker_x += STEP_DX[pick];
        walker_y += STEP_DY[pick];
        visited[walker_x + GRID_HALF][walker_y + GRID_HALF] = 1'b1;
        walk_steps = walk_steps + 1'b1;
        // floor(w * count / 3) on a wide product, saturating
        prod = {32'd0, walk_weight} * 64'(count) / 64'd3;
        walk_weight = (prod > 64'hFFFF_FFFF) ? '1 : prod[31:0];
        rep.walk_done = (walk_steps == walk_len);
        if (rep.walk_done)
          walk_running = 1'b0;
        rep.status = ST_MOVED;
      end
    end
    rep.pos_x = POS_W'(walker_x);
    rep.pos_y = POS_W'(walker_y);
    rep.step_index = walk_steps;
    rep.weight = walk_weight;
  endtask

  // ---------------------------------------------------------------------------
  // Shared bench state
  // ---------------------------------------------------------------------------
  walk_item_t   pending_items [$];     // front is the item on the input port
  walk_report_t expected_reports [$];  // one per accepted input, oldest first
  int           accepted_inputs = 0;
  int           mismatches = 0;
  int           items_made = 0;
  logic         bursts_on = 1'b1;      // random idling phases
  logic         quiet = 1'b0;          // end of run: no idling at all
  wire          idle_ok = bursts_on && !quiet;

  // Switch bursty idling on and off so there are stretches without gaps
  always @(posedge clk) begin : burst_mode
    int mode_left;
    if (mode_left <= 0) begin
      bursts_on <= ($urandom_range(0, 3) != 0);
      mode_left = $urandom_range(100, 400);
    end else begin
      mode_left--;
    end
  end

  // ---------------------------------------------------------------------------
  // Input driver. A transfer happens at an edge with in_valid high and
  // in_stall low; the item is predicted right there. Payload holds while
  // stalled, and each port gets one nonblocking write per edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : feeder
    walk_report_t rep;
    logic         offer;
    int           gap_left;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      offer = in_valid;
      if (in_valid && !in_stall) begin
        grow_walk(pending_items[0], rep);
        expected_reports.push_back(rep);
        void'(pending_items.pop_front());
        accepted_inputs <= accepted_inputs + 1;
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() != 0) begin
          if (idle_ok && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(0, 18);
          end else begin
            offer = 1'b1;
            in_operation <= pending_items[0].op;
            in_random_value <= pending_items[0].rnd;
          end
        end
      end
      in_valid <= offer;
    end
  end

  // ---------------------------------------------------------------------------
  // Output stall: random bursts, plus one long hold early on so the block
  // backs up and stalls its input while the driver keeps offering.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : sink_stall
    logic stall;
    int   stall_left;
    int   hold_left;
    bit   hold_done;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (hold_left > 0) begin
        hold_left--;
        stall = 1'b1;
      end else if (!hold_done && accepted_inputs >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        stall = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        stall = 1'b1;
      end else if (idle_ok && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 18);
        stall = 1'b1;
      end else begin
        stall = 1'b0;
      end
      out_stall <= stall;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every result transfer against the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [WEIGHT_W-1:0] want,
                             input logic [WEIGHT_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    walk_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: result transfer with no item pending, status %0d", $time, out_status);
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("pos_x", 32'(want.pos_x), 32'(out_pos_x));
        check_field("pos_y", 32'(want.pos_y), 32'(out_pos_y));
        check_field("step_index", 32'(want.step_index), 32'(out_step_index));
        check_field("weight", want.weight, out_weight);
        check_field("walk_done", 32'(want.walk_done), 32'(out_walk_done));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers (run from the sequencer at falling edges)
  // ---------------------------------------------------------------------------
  task automatic offer_item(input logic op, input int rnd);
    walk_item_t it;
    it.op = op;
    it.rnd = RND_W'(rnd);
    pending_items.push_back(it);
    items_made++;
  endtask

  // start plus nsteps steps; dir < 0 means random picks, else a straight line
  task automatic queue_walk(input int nsteps, input int dir);
    offer_item(OP_START, $urandom_range(0, 32767));
    for (int i = 0; i < nsteps; i++)
      if (dir < 0)
        offer_item(OP_STEP, $urandom_range(0, 32767));
      else
        offer_item(OP_STEP, STRAIGHT_BASE[dir] + 12 * $urandom_range(0, 2729));
  endtask

  // Register writes only once every item has come back
  task automatic write_walk_length(input int value);
    while (pending_items.size() != 0 || expected_reports.size() != 0)
      @(negedge clk);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= STEP_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    walk_len = STEP_W'(value);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer: directed items, then random phases at varied walk lengths
  // ---------------------------------------------------------------------------
  initial begin : sequencer
    int len;
    int nwalks;
    int kind;
    int phase;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(negedge clk);

    // Reset length (50): step with no walk, then a walk that boxes itself in
    // at (1,0) after seven moves, a trapped step and a step after the trap.
    offer_item(OP_STEP, 15'h5555);
    offer_item(OP_START, 15'h2AAA);
    offer_item(OP_STEP, 32765);  // up
    offer_item(OP_STEP, 32767);  // right
    offer_item(OP_STEP, 32765);  // right
    offer_item(OP_STEP, 0);      // down
    offer_item(OP_STEP, 32766);  // down
    offer_item(OP_STEP, 2);      // left
    offer_item(OP_STEP, 1);      // up into the pocket
    offer_item(OP_STEP, 32767);  // trapped
    offer_item(OP_STEP, 0);      // ignored after the trap
    offer_item(OP_START, 0);
    offer_item(OP_STEP, 32767);  // walk left running at one step

    // Length 1: running walk already at its limit, then a one-step walk
    write_walk_length(1);
    offer_item(OP_STEP, 7);
    offer_item(OP_START, 32767);
    offer_item(OP_STEP, 3);      // completes the walk
    offer_item(OP_STEP, 3);      // ignored after completion

    // Length 0: every step ignored
    write_walk_length(0);
    offer_item(OP_START, 1);
    offer_item(OP_STEP, 1);

    // Length lowered below the running walk's step count
    write_walk_length(63);
    offer_item(OP_START, 5);
    offer_item(OP_STEP, 15'h2AAA);
    offer_item(OP_STEP, 15'h5555);
    offer_item(OP_STEP, 15'h7FFF);
    write_walk_length(2);
    offer_item(OP_STEP, 9);
    offer_item(OP_START, 9);
    offer_item(OP_STEP, 4);
    offer_item(OP_STEP, 8);      // done at two steps

    // Random phases. Mostly complete walks with random picks; some cut
    // short by the next start, some stray items.
    items_made = 0;
    phase = 0;
    while (items_made < RANDOM_ITEMS) begin
      if (items_made > RANDOM_ITEMS * 7 / 8)
        quiet = 1'b1;
      case (phase)
        0, 3:    len = 63;
        1:       len = 1;
        2:       len = 0;
        default: begin
          kind = $urandom_range(0, 9);
          len = (kind == 0) ? 1 : (kind == 1) ? 63 : $urandom_range(2, 62);
        end
      endcase
      write_walk_length(len);
      nwalks = (len == 0) ? 1 : $urandom_range(2, 5);
      if (phase == 0) begin
        // straight lines 63 cells out in each direction (the grid edge for up and right), one step past done
        for (int d = 0; d < 4; d++)
          queue_walk(len + 1, d);
      end
      for (int w = 0; w < nwalks && items_made < RANDOM_ITEMS; w++) begin
        kind = $urandom_range(0, 19);
        if (kind < 2)
          queue_walk(len, $urandom_range(0, 3));
        else if (kind < 15)
          queue_walk(len + $urandom_range(0, 2), -1);
        else if (kind < 18)
          queue_walk($urandom_range(0, len), -1);
        else
          for (int n = $urandom_range(1, 4); n > 0; n--)
            offer_item($urandom_range(0, 3) == 0 ? OP_START : OP_STEP,
                       $urandom_range(0, 32767));
      end
      phase++;
    end

    while (pending_items.size() != 0 || expected_reports.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("lattice_self_avoiding_walk_step test passed");
    else
      $display("lattice_self_avoiding_walk_step test failed");
    $finish;
  end

  // Watchdog: a hung handshake ends the run
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("lattice_self_avoiding_walk_step test failed");
    $finish;
  end

endmodule
